@@ rtl/core/ssm_pkg.sv @@
// shared constants, types and command/status bundles of the split selection sort merge block
package ssm_pkg;

	localparam int DEPTH    = 32;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 5;
	localparam int IN_TDATA_W  = ((VALUE_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((VALUE_W + INDEX_W + 7) / 8) * 8;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [CNT_W-1:0]          count_t;
	typedef logic [IDX_W-1:0]          addr_t;

	// commands from the controller to the datapath, decoded from the current state
	typedef struct packed {
		logic load;         // input transfer: store element, start sort on last
		logic row_rd;       // read first element of the current row
		logic row_start;    // take row head as running minimum, read next
		logic scan;         // compare one element against the running minimum
		logic swap_pick;    // write row head to the minimum's place
		logic swap_row;     // write minimum to the row head, advance row
		logic next_half;    // switch range to the upper half
		logic merge_start;  // reset merge pointers, read lower head
		logic head_a_b;     // capture lower head, read upper head
		logic head_b;       // capture upper head
		logic emit;         // load the output register with the smaller head
		logic fill_a;       // refill lower head
		logic fill_b;       // refill upper head
	} cmd_t;

	typedef struct packed {
		logic range_done;   // at most one element left in the current range
		logic scan_more;    // another element remains in the current scan
		logic upper;        // sorting the upper half
		logic take_a;       // lower head goes out next
		logic merge_last;   // next result ends the run
		logic out_free;     // output register can take a result
	} stat_t;

endpackage

@@ rtl/core/split_selection_sort_merge.sv @@
// top level of the split selection sort merge block
// Elements arrive one per cycle on the slave stream and are stored in a 32-entry
// memory; a transfer with tlast ends the list, and elements beyond 32 are dropped.
// The list is then split at floor(n/2), both halves are selection sorted in turn
// through the one memory read port, and the halves are merged onto the master
// stream in ascending order. Each sort row steps through a row read, a head
// capture, the scan and two swap writes; each merged result takes one memory read.
// The block takes no input while a list is being sorted or merged; the final
// result may still wait in the output register while the first element of the
// next list is taken.
module split_selection_sort_merge
	import ssm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample_value
	input  logic                   s_tlast,   // is_last
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // sorted_value, sorted_index, zero fill
	output logic                   m_tlast    // end_of_run
);

	cmd_t               cmd;
	stat_t              st;
	value_t             out_value;
	logic [INDEX_W-1:0] out_index;

	ssm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	ssm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_value  (s_tdata[VALUE_W-1:0]),
		.in_last   (s_tlast),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_value (out_value),
		.out_index (out_index),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{(OUT_TDATA_W - VALUE_W - INDEX_W){1'b0}}, out_index, out_value};

endmodule

@@ rtl/core/ssm_ctrl.sv @@
// controller state machine sequencing load, two selection sorts and the merge
module ssm_ctrl
	import ssm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	input  logic  s_tlast,
	output logic  s_tready,
	input  stat_t st,
	output cmd_t  cmd
);

	typedef enum logic [10:0] {
		S_LOAD   = 11'b000_0000_0001,
		S_ISTART = 11'b000_0000_0010,
		S_IREAD  = 11'b000_0000_0100,
		S_SCAN   = 11'b000_0000_1000,
		S_SWAP1  = 11'b000_0001_0000,
		S_SWAP2  = 11'b000_0010_0000,
		S_RDB    = 11'b000_0100_0000,
		S_LDB    = 11'b000_1000_0000,
		S_EMIT   = 11'b001_0000_0000,
		S_FILLA  = 11'b010_0000_0000,
		S_FILLB  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_LOAD: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid && s_tlast) begin
					state_d = S_ISTART;
				end
			end
			S_ISTART: begin
				if (!st.range_done) begin
					cmd.row_rd = 1'b1;
					state_d    = S_IREAD;
				end else if (st.upper) begin
					cmd.merge_start = 1'b1;
					state_d         = S_RDB;
				end else begin
					cmd.next_half = 1'b1;
				end
			end
			S_IREAD: begin
				cmd.row_start = 1'b1;
				state_d       = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (!st.scan_more) begin
					state_d = S_SWAP1;
				end
			end
			S_SWAP1: begin
				cmd.swap_pick = 1'b1;
				state_d       = S_SWAP2;
			end
			S_SWAP2: begin
				cmd.swap_row = 1'b1;
				state_d      = S_ISTART;
			end
			S_RDB: begin
				cmd.head_a_b = 1'b1;
				state_d      = S_LDB;
			end
			S_LDB: begin
				cmd.head_b = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.merge_last) begin
						state_d = S_LOAD;
					end else if (st.take_a) begin
						state_d = S_FILLA;
					end else begin
						state_d = S_FILLB;
					end
				end
			end
			S_FILLA: begin
				cmd.fill_a = 1'b1;
				state_d    = S_EMIT;
			end
			S_FILLB: begin
				cmd.fill_b = 1'b1;
				state_d    = S_EMIT;
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

endmodule

@@ rtl/core/ssm_datapath.sv @@
// element store, sort and merge pointers, comparators and output register
module ssm_datapath
	import ssm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              st,
	input  value_t             in_value,
	input  logic               in_last,
	input  logic               out_ready,
	output logic               out_valid,
	output value_t             out_value,
	output logic [INDEX_W-1:0] out_index,
	output logic               out_last
);

	value_t mem [DEPTH];
	value_t rdata_q;

	count_t cnt_q, n_q, half_q, hi_q, i_q, j_q, a_q, b_q, k_q;
	addr_t  pick_q;
	value_t cur_q, min_q, ha_q, hb_q;
	logic   upper_q, out_valid_q;

	logic   we;
	addr_t  waddr, raddr;
	value_t wdata;
	count_t i_inc, j_inc, a_inc, b_inc, k_inc, n_next;
	logic   has_room, take_a;

	assign has_room = cnt_q < count_t'(DEPTH);
	assign n_next   = has_room ? count_t'(cnt_q + 1'b1) : cnt_q;
	assign i_inc    = i_q + 1'b1;
	assign j_inc    = j_q + 1'b1;
	assign a_inc    = a_q + 1'b1;
	assign b_inc    = b_q + 1'b1;
	assign k_inc    = k_q + 1'b1;

	assign take_a = (a_q < half_q) && ((b_q >= n_q) || (ha_q < hb_q));

	always_comb begin
		st            = '0;
		st.range_done = {1'b0, i_q} + 1'b1 >= {1'b0, hi_q};
		st.scan_more  = {1'b0, j_q} + 1'b1 <  {1'b0, hi_q};
		st.upper      = upper_q;
		st.take_a     = take_a;
		st.merge_last = {1'b0, k_q} + 1'b1 == {1'b0, n_q};
		st.out_free   = !out_valid_q || out_ready;
	end

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[IDX_W-1:0];
		wdata = in_value;
		if (cmd.load && has_room) begin
			we = 1'b1;
		end else if (cmd.swap_pick) begin
			we    = 1'b1;
			waddr = pick_q;
			wdata = cur_q;
		end else if (cmd.swap_row) begin
			we    = 1'b1;
			waddr = i_q[IDX_W-1:0];
			wdata = min_q;
		end
	end

	always_comb begin
		raddr = i_q[IDX_W-1:0];
		if (cmd.row_start) begin
			raddr = i_inc[IDX_W-1:0];
		end else if (cmd.scan) begin
			raddr = j_inc[IDX_W-1:0];
		end else if (cmd.merge_start) begin
			raddr = '0;
		end else if (cmd.head_a_b) begin
			raddr = b_q[IDX_W-1:0];
		end else if (cmd.emit) begin
			raddr = take_a ? a_inc[IDX_W-1:0] : b_inc[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			upper_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= n_next;
				if (in_last) begin
					upper_q <= 1'b0;
				end
			end else if (cmd.emit && st.merge_last) begin
				cnt_q <= '0;
			end
			if (cmd.next_half) begin
				upper_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && in_last) begin
			n_q    <= n_next;
			half_q <= n_next >> 1;
			hi_q   <= n_next >> 1;
			i_q    <= '0;
		end
		if (cmd.next_half) begin
			i_q  <= half_q;
			hi_q <= n_q;
		end
		if (cmd.row_start) begin
			cur_q  <= rdata_q;
			min_q  <= rdata_q;
			pick_q <= i_q[IDX_W-1:0];
			j_q    <= i_inc;
		end
		if (cmd.scan) begin
			if (rdata_q < min_q) begin
				min_q  <= rdata_q;
				pick_q <= j_q[IDX_W-1:0];
			end
			j_q <= j_inc;
		end
		if (cmd.swap_row) begin
			i_q <= i_inc;
		end
		if (cmd.merge_start) begin
			a_q <= '0;
			b_q <= half_q;
			k_q <= '0;
		end
		if (cmd.head_a_b || cmd.fill_a) begin
			ha_q <= rdata_q;
		end
		if (cmd.head_b || cmd.fill_b) begin
			hb_q <= rdata_q;
		end
		if (cmd.emit) begin
			out_value <= take_a ? ha_q : hb_q;
			out_index <= INDEX_W'(k_q);
			out_last  <= st.merge_last;
			k_q       <= k_inc;
			if (take_a) begin
				a_q <= a_inc;
			end else begin
				b_q <= b_inc;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/core/ssm_checker.sv @@
// port-level checker for the split selection sort merge block, bound to the top level
module ssm_checker
	import ssm_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   s_tlast,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tlast
);

	logic [1:0]         pend_q;
	logic [INDEX_W-1:0] exp_idx_q;
	value_t             prev_q;
	logic               s_xfer, m_xfer, s_end, m_end;

	assign s_xfer = s_tvalid && s_tready;
	assign m_xfer = m_tvalid && m_tready;
	assign s_end  = s_xfer && s_tlast;
	assign m_end  = m_xfer && m_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			exp_idx_q <= '0;
			prev_q    <= '0;
		end else begin
			// lists taken whose final result has not left yet
			if (s_end && !m_end) begin
				pend_q <= pend_q + 2'd1;
			end else if (m_end && !s_end) begin
				pend_q <= pend_q - 2'd1;
			end
			if (m_xfer) begin
				exp_idx_q <= m_tlast ? '0 : exp_idx_q + 1'b1;
				prev_q    <= m_tdata[VALUE_W-1:0];
			end
		end
	end

	// a stalled result transfer holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// results appear only for a list whose last element was taken
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result without a finished list");

	// no input is taken while a list is still being sorted or merged
	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd2) || (pend_q == 2'd1 && !(m_tvalid && m_tlast)) |-> !s_tready)
		else $error("input taken during sort");

	// indices count up from zero within a run
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[VALUE_W+INDEX_W-1:VALUE_W] == exp_idx_q)
		else $error("wrong sorted index");

	// values never decrease within a run
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && exp_idx_q != '0 |-> $signed(m_tdata[VALUE_W-1:0]) >= prev_q)
		else $error("results out of order");

endmodule

bind split_selection_sort_merge ssm_checker u_ssm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
